>>> rtl/rcs_pkg.sv
// ----------------------------------------------------------------------------
// rcs_pkg
// shared constants and types of the rgba channel statistics block
// ----------------------------------------------------------------------------
package rcs_pkg;

    localparam int CHANNELS   = 4;
    localparam int PIX_W      = 8;
    localparam int SUM_W      = 32;
    localparam int MEAN_W     = 16;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COUNT_W    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int PROD_W     = 2 * CFG_W;
    localparam int DIV_STEPS  = MEAN_W;
    localparam int STEP_W     = $clog2(DIV_STEPS + 1);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // channel order inside an item
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    typedef struct packed {
        logic [PIX_W-1:0]  lo;
        logic [PIX_W-1:0]  hi;
        logic [MEAN_W-1:0] mean;
    } lane_res_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lane_stat_t;

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        if (v == '0)
            r = CFG_W'(1);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage

>>> rtl/rcs_if.sv
// ----------------------------------------------------------------------------
// rcs_if
// valid/ready channels for pixel items and statistics items
// ----------------------------------------------------------------------------
interface rcs_pix_if
    import rcs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;

    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface rcs_stat_if
    import rcs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  red_min;
    logic [PIX_W-1:0]  red_max;
    logic [MEAN_W-1:0] red_mean;
    logic [PIX_W-1:0]  green_min;
    logic [PIX_W-1:0]  green_max;
    logic [MEAN_W-1:0] green_mean;
    logic [PIX_W-1:0]  blue_min;
    logic [PIX_W-1:0]  blue_max;
    logic [MEAN_W-1:0] blue_mean;
    logic [PIX_W-1:0]  alpha_min;
    logic [PIX_W-1:0]  alpha_max;
    logic [MEAN_W-1:0] alpha_mean;

    modport source (output valid, red_min, red_max, red_mean, green_min, green_max,
                    green_mean, blue_min, blue_max, blue_mean, alpha_min, alpha_max,
                    alpha_mean, input ready);
    modport sink (input valid, red_min, red_max, red_mean, green_min, green_max,
                  green_mean, blue_min, blue_max, blue_mean, alpha_min, alpha_max,
                  alpha_mean, output ready);
endinterface

>>> rtl/rcs_lane.sv
// ----------------------------------------------------------------------------
// rcs_lane
// one channel: running min, max and sum, then a serial divide for the mean
// ----------------------------------------------------------------------------
module rcs_lane
    import rcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [PIX_W-1:0]   pix,
    input  logic               first,
    input  logic               last,
    input  logic [COUNT_W-1:0] count,
    input  logic               take,
    output lane_stat_t         stat,
    output lane_res_t          res
);

    logic [PIX_W-1:0]   lo_reg, lo_next;
    logic [PIX_W-1:0]   hi_reg, hi_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [COUNT_W-1:0] rem_reg;
    logic [MEAN_W-1:0]  quo_reg;
    logic [COUNT_W-1:0] dvs_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic [PIX_W-1:0]   res_lo_reg;
    logic [PIX_W-1:0]   res_hi_reg;
    logic               done;
    logic [COUNT_W+1:0] diff;

    always_comb
    begin
        if (first)
        begin
            lo_next = pix;
            hi_next = pix;
        end
        else
        begin
            lo_next = (pix < lo_reg) ? pix : lo_reg;
            hi_next = (pix > hi_reg) ? pix : hi_reg;
        end
        sum_next = sum_reg + SUM_W'(pix);
    end

    // restoring step: remainder stays below the divisor
    assign diff = {1'b0, rem_reg, quo_reg[MEAN_W-1]} - {2'b00, dvs_reg};
    assign done = (step_reg == STEP_W'(DIV_STEPS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                if (last)
                begin
                    sum_reg  <= '0;
                    busy_reg <= 1'b1;
                    step_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_next;
                end
            end
            else if (busy_reg)
            begin
                if (!done)
                    step_reg <= step_reg + STEP_W'(1);
                else if (take)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            if (last)
            begin
                res_lo_reg <= lo_next;
                res_hi_reg <= hi_next;
                // dividend is sum * 256; the top bits seed the remainder
                rem_reg    <= COUNT_W'(sum_next[SUM_W-1:PIX_W]);
                quo_reg    <= {sum_next[PIX_W-1:0], {(MEAN_W-PIX_W){1'b0}}};
                dvs_reg    <= count;
            end
        end
        else if (busy_reg && !done)
        begin
            if (!diff[COUNT_W+1])
            begin
                rem_reg <= diff[COUNT_W-1:0];
                quo_reg <= {quo_reg[MEAN_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[COUNT_W-2:0], quo_reg[MEAN_W-1]};
                quo_reg <= {quo_reg[MEAN_W-2:0], 1'b0};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && done;
    assign res.lo    = res_lo_reg;
    assign res.hi    = res_hi_reg;
    assign res.mean  = quo_reg;

endmodule

>>> rtl/rcs_merge.sv
// ----------------------------------------------------------------------------
// rcs_merge
// gathers the lane results into the registered statistics output
// ----------------------------------------------------------------------------
module rcs_merge
    import rcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lane_stat_t  stat,
    input  lane_res_t   res [CHANNELS],
    output logic        take,
    rcs_stat_if.source  stat_out
);

    logic      valid_reg;
    lane_res_t data_reg [CHANNELS];

    assign take = stat.done && (!valid_reg || stat_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= 1'b1;
        else if (stat_out.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            data_reg <= res;
    end

    assign stat_out.valid      = valid_reg;
    assign stat_out.red_min    = data_reg[CH_RED].lo;
    assign stat_out.red_max    = data_reg[CH_RED].hi;
    assign stat_out.red_mean   = data_reg[CH_RED].mean;
    assign stat_out.green_min  = data_reg[CH_GREEN].lo;
    assign stat_out.green_max  = data_reg[CH_GREEN].hi;
    assign stat_out.green_mean = data_reg[CH_GREEN].mean;
    assign stat_out.blue_min   = data_reg[CH_BLUE].lo;
    assign stat_out.blue_max   = data_reg[CH_BLUE].hi;
    assign stat_out.blue_mean  = data_reg[CH_BLUE].mean;
    assign stat_out.alpha_min  = data_reg[CH_ALPHA].lo;
    assign stat_out.alpha_max  = data_reg[CH_ALPHA].hi;
    assign stat_out.alpha_mean = data_reg[CH_ALPHA].mean;

endmodule

>>> rtl/rgba_channel_statistics_core.sv
// ----------------------------------------------------------------------------
// rgba_channel_statistics_core
// per-frame min, max and mean of each rgba channel
// ----------------------------------------------------------------------------
// pix_in takes one pixel item per clock in raster order; stat_out gives one
// statistics item per frame, after the pixel that completes width times height
// cfg_we/cfg_index/cfg_data write frame_width (index 0) and frame_height
// (index 1) while the block is idle; zero counts as 1, big values saturate
// four channel lanes work side by side, each keeping min, max and a 32-bit sum
// throughput: one pixel item per cycle within a frame
// the frame's last pixel starts a 16-step restoring divide in every lane
// (sum * 256 / pixel count); pix_in.ready stays low during the divide and
// until the results are handed to the output register, so no pixel of the
// next frame is taken before then; the statistics item is registered when
// the lanes hand their results over
// if the receiver stalls, the item waits in the output register; a second
// finished frame then holds in the lanes and pix_in.ready stays low
// reset clears the pixel count, sums and output valid, and sets both sizes to 1
// ----------------------------------------------------------------------------
module rgba_channel_statistics_core
    import rcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    rcs_pix_if.sink              pix_in,
    rcs_stat_if.source           stat_out
);

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [COUNT_W-1:0] target;
    logic [COUNT_W-1:0] seen_reg, seen_next;
    logic [PROD_W-1:0]  product;
    logic               accept;
    logic               first;
    logic               last;
    logic               take;
    logic [PIX_W-1:0]   px [CHANNELS];
    lane_stat_t         lane_stat [CHANNELS];
    lane_res_t          lane_res [CHANNELS];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // frame size product, follows a size write at once
    assign product = clamp_size(width_reg, CFG_W'(MAX_WIDTH)) *
                     clamp_size(height_reg, CFG_W'(MAX_HEIGHT));
    assign target  = product[COUNT_W-1:0];

    // pixel counting
    assign pix_in.ready = !lane_stat[0].busy;
    assign accept       = pix_in.valid && pix_in.ready;
    assign seen_next    = seen_reg + COUNT_W'(1);
    assign first        = (seen_reg == '0);
    assign last         = (seen_next >= target) || (seen_next == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= '0;
        else if (accept)
            seen_reg <= last ? '0 : seen_next;
    end

    assign px[CH_RED]   = pix_in.red;
    assign px[CH_GREEN] = pix_in.green;
    assign px[CH_BLUE]  = pix_in.blue;
    assign px[CH_ALPHA] = pix_in.alpha;

    // one lane per channel; all lanes run in lockstep
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        rcs_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .accept(accept),
            .pix   (px[c]),
            .first (first),
            .last  (last),
            .count (seen_next),
            .take  (take),
            .stat  (lane_stat[c]),
            .res   (lane_res[c])
        );
    end

    // merge lanes into the output register
    rcs_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .stat    (lane_stat[0]),
        .res     (lane_res),
        .take    (take),
        .stat_out(stat_out)
    );

`ifndef SYNTH
    // lanes must stay in lockstep
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_stat[0] == lane_stat[1]) && (lane_stat[0] == lane_stat[2]) &&
        (lane_stat[0] == lane_stat[3]))
        else $error("channel lanes out of step");

    // the frame's last pixel starts the divide
    a_last_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (lane_stat[0].busy && !pix_in.ready))
        else $error("frame end did not start the divide");

    // a new statistics item only follows a finished divide
    a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(stat_out.valid) |-> $past(lane_stat[0].done))
        else $error("statistics item without a finished divide");

    // pixel count is cleared whenever the lanes hold a finished frame
    a_seen_clear: assert property (@(posedge clk) disable iff (!rst_n)
        lane_stat[0].busy |-> (seen_reg == '0))
        else $error("pixel count not cleared at frame end");
`endif

endmodule
